// ----- src/hcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcd_pkg: shared types, codes and mod-26 helpers
// Holds the letter width, status codes, register indexes, the derived-matrix
// bundle, the result record and small constant-divisor arithmetic.
// ----------------------------------------------------------------------------
package hcd_pkg;

    localparam int LETTER_W = 5;

    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd25;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DET_ZERO = 2'd1;
    localparam logic [1:0] ST_NOT_INV  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_TL = 2'd0;
    localparam logic [1:0] REG_KEY_TR = 2'd1;
    localparam logic [1:0] REG_KEY_BL = 2'd2;
    localparam logic [1:0] REG_KEY_BR = 2'd3;

    // Decryption matrix and key status, as seen by the letter datapath
    typedef struct packed {
        logic [1:0]          status;
        logic [LETTER_W-1:0] m00;
        logic [LETTER_W-1:0] m01;
        logic [LETTER_W-1:0] m10;
        logic [LETTER_W-1:0] m11;
    } key_mat_t;

    // One result word
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                line_end;
        logic                last;
        logic [1:0]          status;
    } result_t;

    // v mod 26 for v below 2048: quotient estimate v*39/1024 is exact or one
    // low, so a single conditional subtract finishes the remainder.
    function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] v);
        logic [16:0] prod;
        logic [10:0] qm;
        logic [10:0] r;
        prod = 17'(v) * 17'd39;
        qm   = 11'(prod[16:10]) * 11'd26;
        r    = v - qm;
        if (r >= 11'd26)
        begin
            r = r - 11'd26;
        end
        return r[LETTER_W-1:0];
    endfunction

    // Reduce a 5-bit key letter (0..31) into 0..25
    function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] v);
        return (v >= MODULUS) ? v - MODULUS : v;
    endfunction

    // Additive inverse mod 26 of a 5-bit key letter
    function automatic logic [LETTER_W-1:0] neg26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = red26(v);
        return (r == 5'd0) ? 5'd0 : MODULUS - r;
    endfunction

    // Multiplicative inverse mod 26; zero where none exists
    function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/hcd_key_prep.sv -----
// ----------------------------------------------------------------------------
// hcd_key_prep: key registers and inverse-matrix derivation
// Holds the four key letters, checks the determinant and forms the inverse
// matrix mod 26 over two register stages.
// ----------------------------------------------------------------------------
module hcd_key_prep
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [hcd_pkg::LETTER_W-1:0] cfg_data,
    output hcd_pkg::key_mat_t            mat
);

    logic [hcd_pkg::LETTER_W-1:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg;

    // Stage A: determinant checks, inverse and reduced adjugate
    logic [1:0]                   st_a_reg, st_a_next;
    logic [hcd_pkg::LETTER_W-1:0] inv_a_reg, inv_a_next;
    logic [hcd_pkg::LETTER_W-1:0] adj_d_reg, adj_b_reg, adj_c_reg, adj_a_reg;

    hcd_pkg::key_mat_t mat_reg, mat_next;

    logic [9:0]                   prod_ad, prod_bc;
    logic [hcd_pkg::LETTER_W-1:0] ad_m, bc_m, det_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= 5'd1;
            key_b_reg <= 5'd0;
            key_c_reg <= 5'd0;
            key_d_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hcd_pkg::REG_KEY_TL: key_a_reg <= cfg_data;
                hcd_pkg::REG_KEY_TR: key_b_reg <= cfg_data;
                hcd_pkg::REG_KEY_BL: key_c_reg <= cfg_data;
                hcd_pkg::REG_KEY_BR: key_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prod_ad = 10'(key_a_reg) * 10'(key_d_reg);
        prod_bc = 10'(key_b_reg) * 10'(key_c_reg);
        ad_m    = hcd_pkg::mod26(11'(prod_ad));
        bc_m    = hcd_pkg::mod26(11'(prod_bc));
        det_m   = (ad_m >= bc_m) ? ad_m - bc_m : ad_m + hcd_pkg::MODULUS - bc_m;

        // Raw determinant zero, else even or a multiple of thirteen
        if (prod_ad == prod_bc)
        begin
            st_a_next = hcd_pkg::ST_DET_ZERO;
        end
        else if ((prod_ad[0] == prod_bc[0]) || (det_m == 5'd0) || (det_m == 5'd13))
        begin
            st_a_next = hcd_pkg::ST_NOT_INV;
        end
        else
        begin
            st_a_next = hcd_pkg::ST_OK;
        end
        inv_a_next = hcd_pkg::inv26(det_m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_a_reg  <= hcd_pkg::ST_OK;
            inv_a_reg <= 5'd1;
            adj_d_reg <= 5'd1;
            adj_b_reg <= 5'd0;
            adj_c_reg <= 5'd0;
            adj_a_reg <= 5'd1;
        end
        else
        begin
            st_a_reg  <= st_a_next;
            inv_a_reg <= inv_a_next;
            adj_d_reg <= hcd_pkg::red26(key_d_reg);
            adj_b_reg <= hcd_pkg::neg26(key_b_reg);
            adj_c_reg <= hcd_pkg::neg26(key_c_reg);
            adj_a_reg <= hcd_pkg::red26(key_a_reg);
        end
    end

    // Stage B: scale the adjugate by the inverse determinant
    always_comb
    begin
        mat_next.status = st_a_reg;
        mat_next.m00    = hcd_pkg::mod26(11'(10'(adj_d_reg) * 10'(inv_a_reg)));
        mat_next.m01    = hcd_pkg::mod26(11'(10'(adj_b_reg) * 10'(inv_a_reg)));
        mat_next.m10    = hcd_pkg::mod26(11'(10'(adj_c_reg) * 10'(inv_a_reg)));
        mat_next.m11    = hcd_pkg::mod26(11'(10'(adj_a_reg) * 10'(inv_a_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg.status <= hcd_pkg::ST_OK;
            mat_reg.m00    <= 5'd1;
            mat_reg.m01    <= 5'd0;
            mat_reg.m10    <= 5'd0;
            mat_reg.m11    <= 5'd1;
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

// ----- src/hill_cipher_2x2_decrypt_top.sv -----
// ----------------------------------------------------------------------------
// hill_cipher_2x2_decrypt_top: 2x2 Hill cipher decryption mod 26
// Pairs ciphertext letters per line, multiplies each pair by the inverse key
// matrix and streams out plaintext letters, one result word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
// The first result word of a letter reaches m_tvalid through the input register,
//   then the pair logic into the result queue; a full queue can stall it there.
// Throughput: one letter per cycle while the queue has room and no key write holds
//   s_tready low; odd line-end letters make two words each and are then paced by the one-word-per-cycle output port.
// A key write holds s_tready low while cfg_we is high and while settle_reg is set. Reset loads
//   the identity key and clears the held letter and the queue.
module hill_cipher_2x2_decrypt_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,

    // Ciphertext in
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] cipher_letter, [7:5] zero
    input  logic       s_tlast,   // line_end

    // Plaintext out
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] plain_letter, [7:5] zero
    output logic       m_tlast,   // plain_line_end
    output logic [2:0] m_tuser,   // [0] run_last, [2:1] status

    // Key configuration
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    hcd_pkg::key_mat_t mat;

    hcd_key_prep u_key_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    // Hold off letters in the cycle after a key write
    logic settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 1'b0;
        end
        else
        begin
            settle_reg <= cfg_we;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                         in_valid_reg;
    logic [hcd_pkg::LETTER_W-1:0] in_letter_reg;
    logic                         in_le_reg;
    logic                         in_take;
    logic                         fire;

    assign s_tready = (!in_valid_reg || fire) && !cfg_we && !settle_reg;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_letter_reg <= s_tdata[hcd_pkg::LETTER_W-1:0];
            in_le_reg     <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Pair logic: hold the first letter, emit two letters on the second,
    // pad a lone line-end letter with Z, or emit one status word on a bad key
    // ------------------------------------------------------------------
    logic                         held_valid_reg, held_valid_next;
    logic [hcd_pkg::LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic [1:0]                   n_res;
    logic                         space_ok;
    hcd_pkg::result_t             res0, res1;
    logic [hcd_pkg::LETTER_W-1:0] x, y;
    logic [9:0]                   p00, p10, p01, p11;

    logic [PTR_W-1:0] head_reg, tail_reg, tail_inc;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    always_comb
    begin
        x = held_valid_reg ? held_letter_reg : in_letter_reg;
        y = held_valid_reg ? in_letter_reg : hcd_pkg::PAD_LETTER;
        p00 = 10'(x) * 10'(mat.m00);
        p10 = 10'(y) * 10'(mat.m10);
        p01 = 10'(x) * 10'(mat.m01);
        p11 = 10'(y) * 10'(mat.m11);

        res0.letter   = hcd_pkg::mod26(11'(p00) + 11'(p10));
        res0.line_end = 1'b0;
        res0.last     = 1'b0;
        res0.status   = hcd_pkg::ST_OK;
        res1.letter   = hcd_pkg::mod26(11'(p01) + 11'(p11));
        res1.line_end = in_le_reg;
        res1.last     = 1'b1;
        res1.status   = hcd_pkg::ST_OK;

        held_valid_next  = 1'b0;
        held_letter_next = held_letter_reg;

        if (mat.status != hcd_pkg::ST_OK)
        begin
            // Bad key: drop any held letter, one status word per letter
            n_res         = 2'd1;
            res0.letter   = '0;
            res0.line_end = in_le_reg;
            res0.last     = 1'b1;
            res0.status   = mat.status;
        end
        else if (!held_valid_reg && !in_le_reg)
        begin
            n_res            = 2'd0;
            held_valid_next  = 1'b1;
            held_letter_next = in_letter_reg;
        end
        else
        begin
            n_res = 2'd2;
        end

        case (n_res)
            2'd0:    space_ok = 1'b1;
            2'd1:    space_ok = (count_reg < CNT_FULL);
            default: space_ok = (count_reg < CNT_W'(QUEUE_DEPTH - 1));
        endcase
    end

    assign fire = in_valid_reg && space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
        end
        else if (fire)
        begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: takes up to two words per cycle, drains one
    // ------------------------------------------------------------------
    hcd_pkg::result_t q_reg [QUEUE_DEPTH];

    assign pop      = m_tvalid && m_tready;
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (fire && (n_res != 2'd0))
        begin
            q_reg[tail_reg] <= res0;
            if (n_res == 2'd2)
            begin
                q_reg[tail_inc] <= res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            end
            if (fire && (n_res == 2'd1))
            begin
                tail_reg <= tail_inc;
            end
            else if (fire && (n_res == 2'd2))
            begin
                tail_reg <= (tail_inc == PTR_LAST) ? '0 : tail_inc + 1'b1;
            end
            count_reg <= count_reg + (fire ? CNT_W'(n_res) : '0) - CNT_W'(pop);
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {3'b000, q_reg[head_reg].letter};
    assign m_tlast  = q_reg[head_reg].line_end;
    assign m_tuser  = {q_reg[head_reg].status, q_reg[head_reg].last};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("result queue overfilled");

    a_error_drops_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (mat.status != hcd_pkg::ST_OK)) |=> !held_valid_reg)
        else $error("held letter kept across a status word");

    a_error_zero_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[2:1] != hcd_pkg::ST_OK)) |-> (m_tdata == 8'd0))
        else $error("status word carries a nonzero letter");

    a_no_take_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_take)
        else $error("letter accepted while matrix settles");

endmodule
